>>> rtl/core/kls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kls_pkg;

  localparam int MAX_TOKEN_BUF = 256;
  localparam int POSITION_BITS = 32;
  localparam int LEN_W         = 8;
  localparam int OFFSET_W      = 32;
  localparam int PREFIX_LEN    = 8;
  localparam int PFX_W         = $clog2(PREFIX_LEN);
  localparam int KW_COUNT      = 6;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_W'(MAX_TOKEN_BUF - 1);
  localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_TOKEN_BUF - 2);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [4:0] {
    TK_LPAREN = 5'd0, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK,
    TK_LT, TK_GT, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT, TK_AMP,
    TK_PIPE, TK_CARET, TK_BANG, TK_EQ, TK_COMMA, TK_COLON, TK_SEMI, TK_END,
    TK_KW_FUNCTION, TK_KW_LET, TK_KW_IF, TK_KW_FOR, TK_KW_WHILE, TK_KW_RETURN,
    TK_NUMBER, TK_IDENT, TK_STRING, TK_OVERLONG
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WORD = 3'b010,
    MODE_STR  = 3'b100
  } scan_mode_t;

  typedef struct packed {
    tok_kind_t            kind;
    logic [OFFSET_W-1:0]  start;
    logic [LEN_W-1:0]     len;
    logic                 last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  typedef struct packed {
    logic             hit;
    tok_kind_t        kind;
  } op_res_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [1:0]       per;
    logic             snd;
  } absorb_t;

  // prefix byte 0 sits in the top byte
  localparam logic [PREFIX_LEN-1:0][7:0] KW_TEXT [KW_COUNT] = '{
    "function", {"let", 40'h0}, {"if", 48'h0}, {"for", 40'h0},
    {"while", 24'h0}, {"return", 16'h0}
  };
  localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    LEN_W'(8), LEN_W'(3), LEN_W'(2), LEN_W'(3), LEN_W'(5), LEN_W'(6)
  };
  localparam tok_kind_t KW_KIND [KW_COUNT] = '{
    TK_KW_FUNCTION, TK_KW_LET, TK_KW_IF, TK_KW_FOR, TK_KW_WHILE, TK_KW_RETURN
  };

  function automatic op_res_t op_lookup(input logic [7:0] b);
    op_res_t r;
    r.hit = 1'b1;
    case (b)
      "(":     r.kind = TK_LPAREN;
      ")":     r.kind = TK_RPAREN;
      "{":     r.kind = TK_LBRACE;
      "}":     r.kind = TK_RBRACE;
      "[":     r.kind = TK_LBRACK;
      "]":     r.kind = TK_RBRACK;
      "<":     r.kind = TK_LT;
      ">":     r.kind = TK_GT;
      "+":     r.kind = TK_PLUS;
      "-":     r.kind = TK_MINUS;
      "*":     r.kind = TK_STAR;
      "/":     r.kind = TK_SLASH;
      "%":     r.kind = TK_PERCENT;
      "&":     r.kind = TK_AMP;
      "|":     r.kind = TK_PIPE;
      "^":     r.kind = TK_CARET;
      "!":     r.kind = TK_BANG;
      "=":     r.kind = TK_EQ;
      ",":     r.kind = TK_COMMA;
      ":":     r.kind = TK_COLON;
      ";":     r.kind = TK_SEMI;
      default: begin
        r.hit  = 1'b0;
        r.kind = TK_IDENT;
      end
    endcase
    return r;
  endfunction

  function automatic absorb_t absorb(input logic [LEN_W-1:0] len, input logic [1:0] per,
                                     input logic snd, input logic [7:0] b);
    absorb_t r;
    r.len = (len < LEN_SAT) ? len + 1'b1 : len;
    r.per = per;
    r.snd = snd;
    if (b == CH_PERIOD) begin
      if (per < 2'd2) r.per = per + 1'b1;
    end else if (!(b inside {[CH_ZERO:CH_NINE]})) begin
      r.snd = 1'b1;
    end
    return r;
  endfunction

  function automatic tok_kind_t classify(input logic [PREFIX_LEN-1:0][7:0] pfx,
                                         input logic [LEN_W-1:0] len,
                                         input logic [1:0] per, input logic snd);
    tok_kind_t k;
    logic      eq;
    k = (!snd && per <= 2'd1) ? TK_NUMBER : TK_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      eq = (len == KW_LEN[i]);
      for (int j = 0; j < PREFIX_LEN; j++) begin
        if (LEN_W'(j) < len && pfx[PREFIX_LEN-1-j] != KW_TEXT[i][PREFIX_LEN-1-j]) eq = 1'b0;
      end
      if (eq) k = KW_KIND[i];
    end
    return k;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface kls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface kls_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] start_offset;
  logic [7:0]  token_length;
  logic        last;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kls_front.sv
`timescale 1ns / 1ps
`default_nettype none
module kls_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  kls_in_if.sink              in_bus,
  input  wire logic           space_ok,
  output kls_pkg::push_t      push
);
  import kls_pkg::*;

  scan_mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0]      pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]      start_r, start_nxt;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [1:0]                    per_r, per_nxt;
  logic                          snd_r, snd_nxt;
  logic [PREFIX_LEN-1:0][7:0]    pfx_r, pfx_nxt;

  logic       accept;
  logic [7:0] b;
  logic       ws;
  op_res_t    op;
  absorb_t    ab_cont;
  absorb_t    ab_open;
  tok_t       fin_tok;
  tok_t       end_tok;
  logic [LEN_W-1:0] fin_len;
  logic [PFX_W-1:0] pfx_idx;

  assign in_bus.ready = space_ok;
  assign accept  = in_bus.valid && space_ok;
  assign b       = in_bus.char_byte;
  assign ws      = b inside {CH_SPACE, CH_LF, CH_TAB};
  assign op      = op_lookup(b);
  assign ab_cont = absorb(len_r, per_r, snd_r, b);
  assign ab_open = absorb('0, 2'd0, 1'b0, b);
  assign pfx_idx = PFX_W'(PREFIX_LEN - 1) - len_r[PFX_W-1:0];

  // closing quote counts toward the string length
  assign fin_len = (mode_r == MODE_STR && !in_bus.end_of_input) ? ab_cont.len : len_r;

  always_comb begin
    fin_tok.start = OFFSET_W'(start_r);
    fin_tok.last  = !in_bus.end_of_input;
    if (fin_len > LEN_OVER) begin
      fin_tok.kind = TK_OVERLONG;
      fin_tok.len  = LEN_SAT;
    end else begin
      fin_tok.kind = (mode_r == MODE_STR) ? TK_STRING : classify(pfx_r, len_r, per_r, snd_r);
      fin_tok.len  = fin_len;
    end
    end_tok.kind  = TK_END;
    end_tok.start = OFFSET_W'(pos_r);
    end_tok.len   = '0;
    end_tok.last  = 1'b1;
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    per_nxt   = per_r;
    snd_nxt   = snd_r;
    pfx_nxt   = pfx_r;
    push      = '0;
    if (accept) begin
      if (in_bus.end_of_input) begin
        if (mode_r != MODE_IDLE) begin
          push.cnt = 2'd2;
          push.t0  = fin_tok;
          push.t1  = end_tok;
        end else begin
          push.cnt = 2'd1;
          push.t0  = end_tok;
        end
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        len_nxt   = '0;
        per_nxt   = 2'd0;
        snd_nxt   = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        case (mode_r)
          MODE_WORD: begin
            if (ws) begin
              push.cnt = 2'd1;
              push.t0  = fin_tok;
              mode_nxt = MODE_IDLE;
            end else begin
              len_nxt = ab_cont.len;
              per_nxt = ab_cont.per;
              snd_nxt = ab_cont.snd;
              if (len_r < LEN_W'(PREFIX_LEN)) pfx_nxt[pfx_idx] = b;
            end
          end
          MODE_STR: begin
            len_nxt = ab_cont.len;
            per_nxt = ab_cont.per;
            snd_nxt = ab_cont.snd;
            if (len_r < LEN_W'(PREFIX_LEN)) pfx_nxt[pfx_idx] = b;
            if (b == CH_QUOTE) begin
              push.cnt = 2'd1;
              push.t0  = fin_tok;
              mode_nxt = MODE_IDLE;
            end
          end
          default: begin
            if (!ws) begin
              if (op.hit) begin
                push.cnt      = 2'd1;
                push.t0.kind  = op.kind;
                push.t0.start = OFFSET_W'(pos_r);
                push.t0.len   = LEN_W'(1);
                push.t0.last  = 1'b1;
              end else begin
                mode_nxt  = (b == CH_QUOTE) ? MODE_STR : MODE_WORD;
                start_nxt = pos_r;
                len_nxt   = ab_open.len;
                per_nxt   = ab_open.per;
                snd_nxt   = ab_open.snd;
                pfx_nxt[PREFIX_LEN-1] = b;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      per_r   <= 2'd0;
      snd_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      per_r   <= per_nxt;
      snd_r   <= snd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pfx_r <= pfx_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/kls_tokq.sv
`timescale 1ns / 1ps
`default_nettype none
module kls_tokq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kls_pkg::push_t push,
  output logic                space_ok,
  kls_out_if.source           out_bus
);
  import kls_pkg::*;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  tok_t              head;

  assign space_ok = count_r <= QCNT_W'(QDEPTH - 2);
  assign head     = mem_r[rd_r];
  assign pop      = out_bus.valid && out_bus.ready;

  assign out_bus.valid        = count_r != '0;
  assign out_bus.token_kind   = head.kind;
  assign out_bus.start_offset = head.start;
  assign out_bus.token_length = head.len;
  assign out_bus.last         = head.last;

  assign wr_nxt    = wr_r + QPTR_W'(push.cnt);
  assign rd_nxt    = rd_r + QPTR_W'(pop);
  assign count_nxt = count_r + QCNT_W'(push.cnt) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.t0;
    if (push.cnt == 2'd2) mem_r[wr_r + 1'b1] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("token queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> space_ok)
    else $error("push without room");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.t1.last && !push.t0.last))
    else $error("last flag misplaced in token pair");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count lost a pop");
`endif

endmodule
`default_nettype wire

>>> rtl/core/keyword_lexer_byte_stream.sv
// a finished token is written into the token queue as the byte that ends it is taken
// throughput: one byte per cycle; end of input with an open token gives two tokens
// the four-entry token queue holds off in_bus.ready when fewer than two slots are free
// reset: synchronous, active low; clears scan state, position and queue at once
`timescale 1ns / 1ps
`default_nettype none
module keyword_lexer_byte_stream (
  input  wire logic clk,
  input  wire logic rst_n,
  kls_in_if.sink    in_bus,
  kls_out_if.source out_bus
);
  import kls_pkg::*;

  push_t push;
  logic  space_ok;

  kls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .space_ok (space_ok),
    .push     (push)
  );

  kls_tokq u_tokq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_bus  (out_bus)
  );

endmodule
`default_nettype wire

>>> test/keyword_lexer_byte_stream_tb.sv
`timescale 1ns / 1ps
module keyword_lexer_byte_stream_tb;
  import kls_pkg::*;

  typedef struct {
    logic [7:0] char_byte;
    logic       end_of_input;
    logic       drain_first;
  } src_item_t;

  localparam int GAP_MAX     = 18;
  localparam int TAIL_ITEMS  = 120;
  localparam int RAND_ITEMS  = 1000;
  localparam int LONG_MAX    = 6;
  localparam int OP_COUNT    = 21;
  localparam logic [8*OP_COUNT-1:0] OP_CHARS = "(){}[]<>+-*/%&|^!=,:;";

  logic clk;
  logic rst_n;

  kls_in_if  in_bus ();
  kls_out_if out_bus ();

  keyword_lexer_byte_stream i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  src_item_t source_bytes[$];
  tok_t      pending_tokens[$];
  int        error_count = 0;
  bit        tail_phase = 0;
  bit        hold_next = 0;

  scan_mode_t               lex_mode;
  logic [POSITION_BITS-1:0] lex_pos;
  logic [POSITION_BITS-1:0] lex_tok_start;
  logic [LEN_W-1:0]         lex_len;
  logic [7:0]               lex_prefix [PREFIX_LEN];
  logic [1:0]               lex_periods;
  logic                     lex_non_digit;

  function automatic int operator_index(input logic [7:0] b);
    for (int i = 0; i < OP_COUNT; i++) begin
      if (OP_CHARS[8*(OP_COUNT-1-i) +: 8] == b) return i;
    end
    return -1;
  endfunction

  function automatic string keyword_text(input int i);
    case (i)
      0:       return "function";
      1:       return "let";
      2:       return "if";
      3:       return "for";
      4:       return "while";
      default: return "return";
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return (b == CH_SPACE || b == CH_LF || b == CH_TAB);
  endfunction

  function automatic void lexer_clear();
    lex_mode      = MODE_IDLE;
    lex_pos       = '0;
    lex_tok_start = '0;
    lex_len       = '0;
    lex_periods   = '0;
    lex_non_digit = 1'b0;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (lex_len < PREFIX_LEN) lex_prefix[lex_len[PFX_W-1:0]] = b;
    if (lex_len < LEN_SAT) lex_len = lex_len + 1'b1;
    if (b == CH_PERIOD) begin
      if (lex_periods < 2'd2) lex_periods = lex_periods + 1'b1;
    end else if (b < CH_ZERO || b > CH_NINE) begin
      lex_non_digit = 1'b1;
    end
  endfunction

  function automatic void open_token(input scan_mode_t mode, input logic [7:0] b);
    lex_mode      = mode;
    lex_tok_start = lex_pos;
    lex_len       = '0;
    lex_periods   = '0;
    lex_non_digit = 1'b0;
    take_byte(b);
  endfunction

  function automatic tok_kind_t word_kind();
    string kw;
    bit    same;
    if (lex_mode == MODE_STR) return TK_STRING;
    for (int i = 0; i < KW_COUNT; i++) begin
      kw = keyword_text(i);
      same = (lex_len == kw.len());
      for (int j = 0; j < kw.len(); j++) begin
        if (same && lex_prefix[j] != kw[j]) same = 1'b0;
      end
      if (same) return tok_kind_t'(int'(TK_KW_FUNCTION) + i);
    end
    if (!lex_non_digit && lex_periods <= 2'd1) return TK_NUMBER;
    return TK_IDENT;
  endfunction

  function automatic tok_t close_token();
    tok_t t;
    t.start = lex_tok_start[OFFSET_W-1:0];
    t.last  = 1'b0;
    if (lex_len > LEN_OVER) begin
      t.kind = TK_OVERLONG;
      t.len  = LEN_SAT;
    end else begin
      t.kind = word_kind();
      t.len  = lex_len;
    end
    lex_mode = MODE_IDLE;
    return t;
  endfunction

  function automatic void predict_tokens(input logic [7:0] b, input logic eoi);
    tok_t res [2];
    int   n;
    int   op;
    n = 0;
    if (eoi) begin
      if (lex_mode != MODE_IDLE) begin
        res[n] = close_token();
        n++;
      end
      res[n].kind  = TK_END;
      res[n].start = lex_pos[OFFSET_W-1:0];
      res[n].len   = '0;
      res[n].last  = 1'b0;
      n++;
      lexer_clear();
    end else begin
      case (lex_mode)
        MODE_WORD: begin
          if (is_blank(b)) begin
            res[n] = close_token();
            n++;
          end else begin
            take_byte(b);
          end
        end
        MODE_STR: begin
          take_byte(b);
          if (b == CH_QUOTE) begin
            res[n] = close_token();
            n++;
          end
        end
        default: begin
          if (!is_blank(b)) begin
            op = operator_index(b);
            if (op >= 0) begin
              res[n].kind  = tok_kind_t'(op);
              res[n].start = lex_pos[OFFSET_W-1:0];
              res[n].len   = LEN_W'(1);
              res[n].last  = 1'b0;
              n++;
            end else if (b == CH_QUOTE) begin
              open_token(MODE_STR, b);
            end else begin
              open_token(MODE_WORD, b);
            end
          end
        end
      endcase
      lex_pos = lex_pos + 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      pending_tokens.push_back(res[i]);
    end
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic eoi);
    src_item_t it;
    it.char_byte    = b;
    it.end_of_input = eoi;
    it.drain_first  = hold_next;
    hold_next       = 1'b0;
    source_bytes.push_back(it);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    add_item(b, 1'b0);
  endfunction

  function automatic void add_eoi();
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_blank();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       add_byte(CH_SPACE);
        1:       add_byte(CH_LF);
        default: add_byte(CH_TAB);
      endcase
    end
  endfunction

  function automatic void add_word_end();
    if ($urandom_range(0, 9) == 0) add_eoi();
    else add_blank();
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] word_head();
    logic [7:0] b;
    do b = word_byte(); while (operator_index(b) >= 0 || b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] string_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic void add_long_token();
    int n;
    case ($urandom_range(0, 5))
      0:       n = 253;
      1:       n = 254;
      2:       n = 255;
      3:       n = 256;
      4:       n = 257;
      default: n = 300;
    endcase
    if ($urandom_range(0, 1) == 0) begin
      add_byte(CH_QUOTE);
      for (int i = 0; i < n - 2; i++) add_byte(string_byte());
      add_byte(CH_QUOTE);
    end else begin
      add_byte(word_head());
      for (int i = 1; i < n; i++) add_byte(word_byte());
      add_word_end();
    end
  endfunction

  function automatic void add_number();
    int n;
    int dot;
    case ($urandom_range(0, 4))
      0: add_text(".");
      1: add_text("..");
      2: begin
        add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        add_text(".");
        add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        add_text(".");
        add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      default: begin
        n   = $urandom_range(1, 8);
        dot = $urandom_range(0, 2 * n);
        for (int i = 0; i < n; i++) begin
          if (i == dot) add_byte(CH_PERIOD);
          else add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
      end
    endcase
    add_word_end();
  endfunction

  function automatic void add_keyword();
    string kw;
    kw = keyword_text($urandom_range(0, KW_COUNT - 1));
    case ($urandom_range(0, 3))
      0: add_text(kw.substr(0, kw.len() - 2));
      1: begin
        add_text(kw);
        add_byte(word_byte());
      end
      default: add_text(kw);
    endcase
    add_word_end();
  endfunction

  function automatic void add_ident();
    int n;
    n = $urandom_range(0, 10);
    add_byte(word_head());
    for (int i = 0; i < n; i++) add_byte(word_byte());
    add_word_end();
  endfunction

  function automatic void add_string();
    int n;
    n = $urandom_range(0, 12);
    add_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) add_byte(string_byte());
    if ($urandom_range(0, 7) == 0) add_eoi();
    else add_byte(CH_QUOTE);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_token();
    tok_t want;
    if (pending_tokens.size() == 0) begin
      $display("%0t: unexpected token, expected none actual kind %0d start %0d length %0d",
               $time, out_bus.token_kind, out_bus.start_offset, out_bus.token_length);
      error_count++;
      return;
    end
    want = pending_tokens.pop_front();
    check_field("token_kind", want.kind, out_bus.token_kind);
    check_field("start_offset", want.start, out_bus.start_offset);
    check_field("token_length", want.len, out_bus.token_length);
    check_field("last", want.last, out_bus.last);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  int in_gap = 0;
  int in_idle_pct = 5;
  int in_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_tokens(in_bus.char_byte, in_bus.end_of_input);
        in_count++;
        if (in_count % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       in_idle_pct = 0;
            1:       in_idle_pct = 5;
            default: in_idle_pct = 20;
          endcase
        end
      end
      tail_phase = (source_bytes.size() < TAIL_ITEMS);
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (source_bytes.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (source_bytes[0].drain_first && pending_tokens.size() != 0) begin
          in_bus.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, GAP_MAX) - 1;
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid        <= 1'b1;
          in_bus.char_byte    <= source_bytes[0].char_byte;
          in_bus.end_of_input <= source_bytes[0].end_of_input;
          void'(source_bytes.pop_front());
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  int out_idle_pct = 3;
  int out_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_token();
        out_count++;
        if (out_count % 48 == 0) begin
          case ($urandom_range(0, 2))
            0:       out_idle_pct = 0;
            1:       out_idle_pct = 3;
            default: out_idle_pct = 12;
          endcase
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(1, GAP_MAX) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int long_count;
    int pick;
    long_count = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.char_byte = '0;
    in_bus.end_of_input = 1'b0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < PREFIX_LEN; i++) lex_prefix[i] = '0;
    lexer_clear();

    // every operator, end of input while idle, an unterminated string,
    // extreme and odd word bytes, a lone period
    add_text("(){}[]<>+-*/%&|^!=,:;");
    add_eoi();
    add_byte(CH_QUOTE);
    add_text("x");
    add_eoi();
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h0d);
    add_byte(CH_TAB);
    add_text(". ");

    hold_next = 1'b1;
    while (source_bytes.size() < RAND_ITEMS) begin
      if ($urandom_range(0, 199) == 0) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 15) add_keyword();
      else if (pick < 30) add_number();
      else if (pick < 45) add_ident();
      else if (pick < 57) add_string();
      else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) add_byte(OP_CHARS[8*$urandom_range(0, OP_COUNT-1) +: 8]);
      end else if (pick < 82) add_byte(8'($urandom_range(0, 255)));
      else if (pick < 86) add_eoi();
      else if (pick < 89 && long_count < LONG_MAX) begin
        add_long_token();
        long_count++;
      end else add_blank();
    end
    add_eoi();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (source_bytes.size() != 0 || in_bus.valid || pending_tokens.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("** keyword_lexer_byte_stream: PASSED **");
    end else begin
      $display("** keyword_lexer_byte_stream: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** keyword_lexer_byte_stream: FAILED **");
    $finish;
  end

endmodule
